>>> src/tos_pkg.sv
package tos_pkg;

  localparam int ORDER_DEPTH = 64;
  localparam int TYPE_DEPTH  = 64;
  localparam int KIND_COUNT  = 5;

  localparam int OA_W  = $clog2(ORDER_DEPTH);
  localparam int OT_W  = $clog2(ORDER_DEPTH + 1);
  localparam int TS_W  = (TYPE_DEPTH > 1) ? $clog2(TYPE_DEPTH) : 1;
  localparam int TT_W  = $clog2(TYPE_DEPTH + 1);
  localparam int VA_W  = $clog2(KIND_COUNT * TYPE_DEPTH);
  localparam int CMP_W = ((OT_W > 7) ? OT_W : 7) + 1;

  localparam logic [2:0] K_INT    = 3'd0;
  localparam logic [2:0] K_LONG   = 3'd1;
  localparam logic [2:0] K_FLOAT  = 3'd2;
  localparam logic [2:0] K_DOUBLE = 3'd3;
  localparam logic [2:0] K_REF    = 3'd4;
  localparam logic [2:0] K_VOID   = 3'd5;
  localparam logic [2:0] K_NARROW = 3'd5;
  localparam logic [2:0] K_WIDE   = 3'd6;
  localparam logic [2:0] K_ANY    = 3'd7;

  typedef enum logic [1:0] {
    FN_PUSH  = 2'd0,
    FN_POP   = 2'd1,
    FN_PEEK  = 2'd2,
    FN_CLEAR = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_BADREAD   = 3'd3,
    ST_BADARG    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_VOID,
    S_POP_TOP,
    S_POP_BASE,
    S_PEEK,
    S_VAL,
    S_OUT
  } state_e;

  function automatic logic kind_wide(input logic [2:0] k);
    return (k == K_LONG) || (k == K_DOUBLE);
  endfunction

  function automatic logic kind_narrow(input logic [2:0] k);
    return (k == K_INT) || (k == K_FLOAT) || (k == K_REF);
  endfunction

  function automatic logic type_accepts(input logic [2:0] want, input logic [2:0] have);
    logic ok;
    if (want == K_ANY) ok = (have < 3'(KIND_COUNT));
    else if (want == K_NARROW) ok = kind_narrow(have);
    else if (want == K_WIDE) ok = kind_wide(have);
    else ok = (want == have);
    return ok;
  endfunction

  function automatic logic [VA_W-1:0] value_addr(input logic [2:0] k,
                                                 input logic [TT_W-1:0] slot);
    return VA_W'(k) * VA_W'(TYPE_DEPTH) + VA_W'(slot);
  endfunction

endpackage

>>> src/tos_ram.sv
module tos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> src/typed_operand_stack_core.sv
// Steps, each ending in S_OUT: push (long/double also S_PUSH_VOID); clear and early
// errors none; pop S_POP_TOP, S_POP_BASE if wide, S_VAL; peek S_PEEK per slot, S_VAL.
// One item at a time; the peek walk reads the type-order memory one slot per cycle.
// A new item is taken while the last result still waits in the output register.
// Reset (async, active low) empties all stacks and sets the capacity to 64; the
// memories are not swept, entries above a top are never read.
module typed_operand_stack_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // func[1:0], push_value[65:2], depth[71:66]
  input  logic [2:0]  s_axis_tuser_i,  // value_type[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,  // status[2:0], read_value[66:3], zero[71:67]
  output logic [2:0]  m_axis_tuser_o,  // read_type[2:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);
  import tos_pkg::*;

  state_e            state_q, state_d;
  logic [OT_W-1:0]   top_q, top_d;
  logic [TT_W-1:0]   tops_q [KIND_COUNT];
  logic [TT_W-1:0]   tops_d [KIND_COUNT];
  logic [TT_W-1:0]   seen_q [KIND_COUNT];
  logic [TT_W-1:0]   seen_d [KIND_COUNT];
  logic [6:0]        cap_q;
  logic [2:0]        t_q, t_d;
  logic [5:0]        depth_q, depth_d;
  logic [5:0]        d_q, d_d;
  logic [OA_W-1:0]   pos_q, pos_d;
  logic              skip_q, skip_d;
  logic              wide_q, wide_d;
  logic [2:0]        res_status_q, res_status_d;
  logic [2:0]        res_type_q, res_type_d;
  logic [63:0]       res_value_q, res_value_d;
  logic              m_valid_q;
  logic [2:0]        out_status_q, out_type_q;
  logic [63:0]       out_value_q;

  logic              ord_we, ord_re, vs_we, vs_re;
  logic [OA_W-1:0]   ord_waddr, ord_raddr;
  logic [2:0]        ord_wdata, ord_rdata;
  logic [VA_W-1:0]   vs_waddr, vs_raddr;
  logic [63:0]       vs_wdata, vs_rdata;

  logic [1:0]        in_func;
  logic [2:0]        in_type;
  logic [63:0]       in_val;
  logic [5:0]        in_depth;
  logic [CMP_W-1:0]  cap_now;
  logic              in_wide, out_free;
  logic              pop_ok;
  logic [TT_W-1:0]   seen_new;

  assign in_func  = s_axis_tdata_i[1:0];
  assign in_val   = s_axis_tdata_i[65:2];
  assign in_depth = s_axis_tdata_i[71:66];
  assign in_type  = s_axis_tuser_i;
  assign in_wide  = kind_wide(in_type);
  assign cap_now  = (CMP_W'(cap_q) > CMP_W'(ORDER_DEPTH)) ? CMP_W'(ORDER_DEPTH)
                                                         : CMP_W'(cap_q);
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign pop_ok   = (ord_rdata < 3'(KIND_COUNT)) && type_accepts(t_q, ord_rdata) &&
                    (kind_wide(ord_rdata) == wide_q);
  assign seen_new = (ord_rdata < 3'(KIND_COUNT)) ? seen_q[ord_rdata] + TT_W'(1) : '0;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_value_q, out_status_q};
  assign m_axis_tuser_o  = out_type_q;

  tos_ram #(.WIDTH(3), .DEPTH(ORDER_DEPTH)) u_order (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(ord_wdata),
    .re_i(ord_re), .raddr_i(ord_raddr), .rdata_o(ord_rdata)
  );

  tos_ram #(.WIDTH(64), .DEPTH(KIND_COUNT * TYPE_DEPTH)) u_values (
    .clk_i, .we_i(vs_we), .waddr_i(vs_waddr), .wdata_i(vs_wdata),
    .re_i(vs_re), .raddr_i(vs_raddr), .rdata_o(vs_rdata)
  );

  always_comb begin
    state_d      = state_q;
    top_d        = top_q;
    tops_d       = tops_q;
    seen_d       = seen_q;
    t_d          = t_q;
    depth_d      = depth_q;
    d_d          = d_q;
    pos_d        = pos_q;
    skip_d       = skip_q;
    wide_d       = wide_q;
    res_status_d = res_status_q;
    res_type_d   = res_type_q;
    res_value_d  = res_value_q;
    ord_we = 1'b0; ord_waddr = '0; ord_wdata = K_VOID;
    ord_re = 1'b0; ord_raddr = '0;
    vs_we  = 1'b0; vs_waddr  = '0; vs_wdata  = '0;
    vs_re  = 1'b0; vs_raddr  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          t_d          = in_type;
          depth_d      = in_depth;
          res_status_d = ST_OK;
          res_type_d   = '0;
          res_value_d  = '0;
          state_d      = S_OUT;
          unique case (func_e'(in_func))
            FN_PUSH: begin
              if (in_type >= 3'(KIND_COUNT)) begin
                res_status_d = ST_BADARG;
              end else if (CMP_W'(top_q) + (in_wide ? CMP_W'(2) : CMP_W'(1)) > cap_now) begin
                res_status_d = ST_OVERFLOW;
              end else if (tops_q[in_type] == TT_W'(TYPE_DEPTH)) begin
                res_status_d = ST_OVERFLOW;
              end else begin
                ord_we    = 1'b1;
                ord_waddr = top_q[OA_W-1:0];
                ord_wdata = in_type;
                vs_we     = 1'b1;
                vs_waddr  = value_addr(in_type, tops_q[in_type]);
                vs_wdata  = in_wide ? in_val : {32'd0, in_val[31:0]};
                tops_d[in_type] = tops_q[in_type] + TT_W'(1);
                top_d     = top_q + (in_wide ? OT_W'(2) : OT_W'(1));
                pos_d     = OA_W'(top_q + OT_W'(1));
                if (in_wide) state_d = S_PUSH_VOID;
              end
            end
            FN_POP: begin
              wide_d = in_wide || (in_type == K_WIDE);
              if (in_type == K_ANY) begin
                res_status_d = ST_BADARG;
              end else if (top_q < ((in_wide || in_type == K_WIDE) ? OT_W'(2) : OT_W'(1))) begin
                res_status_d = ST_UNDERFLOW;
              end else begin
                ord_re    = 1'b1;
                ord_raddr = OA_W'(top_q - OT_W'(1));
                state_d   = S_POP_TOP;
              end
            end
            FN_PEEK: begin
              for (int k = 0; k < KIND_COUNT; k++) seen_d[k] = '0;
              d_d = '0;
              if (top_q == '0) begin
                res_status_d = ST_UNDERFLOW;
              end else begin
                ord_re    = 1'b1;
                ord_raddr = OA_W'(top_q - OT_W'(1));
                pos_d     = OA_W'(top_q - OT_W'(1));
                skip_d    = 1'b0;
                state_d   = S_PEEK;
              end
            end
            FN_CLEAR: begin
              top_d = '0;
              for (int k = 0; k < KIND_COUNT; k++) tops_d[k] = '0;
            end
            default: ;
          endcase
        end
      end

      S_PUSH_VOID: begin
        // upper slot of a wide entry
        ord_we    = 1'b1;
        ord_waddr = pos_q;
        ord_wdata = K_VOID;
        state_d   = S_OUT;
      end

      S_POP_TOP, S_POP_BASE: begin
        if (state_q == S_POP_TOP && wide_q) begin
          if (ord_rdata != K_VOID) begin
            res_status_d = ST_BADREAD;
            state_d      = S_OUT;
          end else begin
            ord_re    = 1'b1;
            ord_raddr = OA_W'(top_q - OT_W'(2));
            state_d   = S_POP_BASE;
          end
        end else if (!pop_ok) begin
          res_status_d = ST_BADREAD;
          state_d      = S_OUT;
        end else if (tops_q[ord_rdata] == '0) begin
          res_status_d = ST_UNDERFLOW;
          state_d      = S_OUT;
        end else begin
          vs_re    = 1'b1;
          vs_raddr = value_addr(ord_rdata, tops_q[ord_rdata] - TT_W'(1));
          tops_d[ord_rdata] = tops_q[ord_rdata] - TT_W'(1);
          top_d      = top_q - (wide_q ? OT_W'(2) : OT_W'(1));
          res_type_d = ord_rdata;
          state_d    = S_VAL;
        end
      end

      S_PEEK: begin
        if (ord_rdata >= 3'(KIND_COUNT)) begin
          // void slot: step once more to the wide entry below
          if (skip_q || pos_q == '0) begin
            res_status_d = ST_UNDERFLOW;
            state_d      = S_OUT;
          end else begin
            ord_re    = 1'b1;
            ord_raddr = pos_q - OA_W'(1);
            pos_d     = pos_q - OA_W'(1);
            skip_d    = 1'b1;
          end
        end else if (d_q == depth_q) begin
          if (seen_new > tops_q[ord_rdata]) begin
            res_status_d = ST_UNDERFLOW;
            state_d      = S_OUT;
          end else if (!type_accepts(t_q, ord_rdata)) begin
            res_status_d = ST_BADREAD;
            state_d      = S_OUT;
          end else begin
            vs_re      = 1'b1;
            vs_raddr   = value_addr(ord_rdata, tops_q[ord_rdata] - seen_new);
            res_type_d = ord_rdata;
            state_d    = S_VAL;
          end
        end else begin
          seen_d[ord_rdata] = seen_new;
          d_d = d_q + 6'd1;
          if (pos_q == '0) begin
            res_status_d = ST_UNDERFLOW;
            state_d      = S_OUT;
          end else begin
            ord_re    = 1'b1;
            ord_raddr = pos_q - OA_W'(1);
            pos_d     = pos_q - OA_W'(1);
            skip_d    = 1'b0;
          end
        end
      end

      S_VAL: begin
        res_value_d = vs_rdata;
        state_d     = S_OUT;
      end

      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      top_q     <= '0;
      cap_q     <= 7'd64;
      m_valid_q <= 1'b0;
      for (int k = 0; k < KIND_COUNT; k++) tops_q[k] <= '0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      tops_q  <= tops_d;
      if (cfg_valid_i) cap_q <= cfg_data_i;
      if (state_q == S_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seen_q       <= seen_d;
    t_q          <= t_d;
    depth_q      <= depth_d;
    d_q          <= d_d;
    pos_q        <= pos_d;
    skip_q       <= skip_d;
    wide_q       <= wide_d;
    res_status_q <= res_status_d;
    res_type_q   <= res_type_d;
    res_value_q  <= res_value_d;
    if (state_q == S_OUT && out_free) begin
      out_status_q <= res_status_q;
      out_type_q   <= (res_status_q == ST_OK) ? res_type_q : 3'd0;
      out_value_q  <= (res_status_q == ST_OK) ? res_value_q : 64'd0;
    end
  end

  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= OT_W'(ORDER_DEPTH))
    else $error("order top beyond depth");

  a_top_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (top_q != top_d) |-> (state_q == S_IDLE || state_q == S_POP_TOP ||
                          state_q == S_POP_BASE))
    else $error("order top changed outside dispatch or pop commit");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_status_q != ST_OK) |-> (out_value_q == '0 && out_type_q == '0))
    else $error("error result carries data");

  a_void_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH_VOID) |-> ($past(state_q) == S_IDLE))
    else $error("void slot write out of sequence");

endmodule
